// File: rtl/jsv_pkg.sv
`timescale 1ns / 1ps

package jsv_pkg;

  // Width of the internal offset and length counters; they saturate at all ones.
  localparam int unsigned OFFSET_BITS = 16;
  localparam int unsigned OUT_BITS    = 16;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  typedef logic [OFFSET_BITS-1:0] offset_t;
  typedef logic [OUT_BITS-1:0]    out_len_t;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_EXPECT       = 2'd1,
    ST_INVALID      = 2'd2,
    ST_NOT_SINGULAR = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    TY_NULL   = 2'd0,
    TY_FALSE  = 2'd1,
    TY_TRUE   = 2'd2,
    TY_NUMBER = 2'd3
  } vtype_e;

  typedef enum logic [3:0] {
    PH_LEAD,
    PH_LIT,
    PH_SIGN,
    PH_ZERO,
    PH_INT,
    PH_DOT,
    PH_FRAC,
    PH_EXP,
    PH_EXPSIGN,
    PH_EXPDIG,
    PH_TRAIL,
    PH_ERR
  } phase_e;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = "+";
  localparam logic [7:0] CH_MINUS = "-";
  localparam logic [7:0] CH_DOT   = ".";
  localparam logic [7:0] CH_0     = "0";
  localparam logic [7:0] CH_1     = "1";
  localparam logic [7:0] CH_9     = "9";
  localparam logic [7:0] CH_UP_E  = "E";
  localparam logic [7:0] CH_A     = "a";
  localparam logic [7:0] CH_E     = "e";
  localparam logic [7:0] CH_F     = "f";
  localparam logic [7:0] CH_L     = "l";
  localparam logic [7:0] CH_N     = "n";
  localparam logic [7:0] CH_R     = "r";
  localparam logic [7:0] CH_S     = "s";
  localparam logic [7:0] CH_T     = "t";
  localparam logic [7:0] CH_U     = "u";
  localparam logic [7:0] CH_X     = "x";

  // A classified character, as it travels from the front end to the parser.
  typedef struct packed {
    logic [7:0] text_byte;
    logic       is_nul;
    logic       is_ws;
    logic       is_digit;
    logic       is_zero;
    logic       is_nonzero;
    logic       is_dot;
    logic       is_exp;
    logic       is_sign;
    logic       is_minus;
    logic       is_lower_x;
  } char_t;

  // Spelling of the literals; past the last letter the result is zero.
  function automatic logic [7:0] lit_char(input vtype_e kind, input logic [2:0] pos);
    logic [7:0] ch;
    ch = CH_NUL;
    case (kind)
      TY_NULL: begin
        case (pos)
          3'd0: ch = CH_N;
          3'd1: ch = CH_U;
          3'd2: ch = CH_L;
          3'd3: ch = CH_L;
          default: ch = CH_NUL;
        endcase
      end
      TY_FALSE: begin
        case (pos)
          3'd0: ch = CH_F;
          3'd1: ch = CH_A;
          3'd2: ch = CH_L;
          3'd3: ch = CH_S;
          3'd4: ch = CH_E;
          default: ch = CH_NUL;
        endcase
      end
      TY_TRUE: begin
        case (pos)
          3'd0: ch = CH_T;
          3'd1: ch = CH_R;
          3'd2: ch = CH_U;
          3'd3: ch = CH_E;
          default: ch = CH_NUL;
        endcase
      end
      default: ch = CH_NUL;
    endcase
    return ch;
  endfunction

  function automatic offset_t sat_inc(input offset_t v);
    return (v == '1) ? v : v + offset_t'(1);
  endfunction

  function automatic out_len_t clamp_out(input offset_t v);
    out_len_t r;
    if ((OFFSET_BITS > OUT_BITS) && (v > offset_t'({OUT_BITS{1'b1}}))) begin
      r = '1;
    end else begin
      r = OUT_BITS'(v);
    end
    return r;
  endfunction

endpackage

// File: rtl/jsv_text_if.sv
`timescale 1ns / 1ps

interface jsv_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink   (input valid, input text_byte, output ready);
endinterface

// File: rtl/jsv_result_if.sv
`timescale 1ns / 1ps

interface jsv_result_if;
  import jsv_pkg::*;

  logic     valid;
  logic     ready;
  status_e  status;
  vtype_e   value_type;
  out_len_t value_start;
  out_len_t value_length;

  modport source (output valid, output status, output value_type, output value_start,
                  output value_length, input ready);
  modport sink   (input valid, input status, input value_type, input value_start,
                  input value_length, output ready);
endinterface

// File: rtl/json_scalar_validator.sv
`timescale 1ns / 1ps
// JSON scalar checker for a byte stream.
// text_i carries one character per request; a zero byte ends a text. Leading and
// trailing whitespace is skipped and exactly one literal (true, false, null) or
// JSON number must stand between. Each zero byte yields one request on result_o:
// status, value type, and the value's byte offset and length (both saturating).
// Bytes other than the terminator yield nothing.
// Throughput: one byte per cycle, sustained, also while results are being sent.
// On its way to result_o the zero byte passes a classifying register, the
// two-entry queue and the parser, whose result is registered.
// When result_o stalls, ordinary bytes keep flowing into the parser; only the
// next terminator waits in the queue, and text_i backs up once the queue and
// the classifier register are full.
// Reset clears the parser to the leading-whitespace state, empties the queue
// and drops any pending result; payload registers are not cleared.
module json_scalar_validator (
  input  logic         clk_i,
  input  logic         rst_ni,
  jsv_text_if.sink     text_i,
  jsv_result_if.source result_o
);
  import jsv_pkg::*;

  logic  front_valid, front_ready;
  char_t front_char;
  logic  pop_valid, pop_ready;
  char_t pop_char;

  jsv_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .text_i       (text_i),
    .char_valid_o (front_valid),
    .char_ready_i (front_ready),
    .char_o       (front_char)
  );

  jsv_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_data_i  (front_char),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_char)
  );

  jsv_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .char_valid_i (pop_valid),
    .char_ready_o (pop_ready),
    .char_i       (pop_char),
    .result_o     (result_o)
  );

endmodule

// File: rtl/jsv_front.sv
`timescale 1ns / 1ps

module jsv_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  jsv_text_if.sink       text_i,
  output logic           char_valid_o,
  input  logic           char_ready_i,
  output jsv_pkg::char_t char_o
);
  import jsv_pkg::*;

  logic  valid_q;
  char_t char_q;
  char_t char_d;

  function automatic char_t classify(input logic [7:0] b);
    char_t c;
    c.text_byte  = b;
    c.is_nul     = (b == CH_NUL);
    c.is_ws      = (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) || (b == CH_CR);
    c.is_digit   = (b >= CH_0) && (b <= CH_9);
    c.is_zero    = (b == CH_0);
    c.is_nonzero = (b >= CH_1) && (b <= CH_9);
    c.is_dot     = (b == CH_DOT);
    c.is_exp     = (b == CH_E) || (b == CH_UP_E);
    c.is_sign    = (b == CH_PLUS) || (b == CH_MINUS);
    c.is_minus   = (b == CH_MINUS);
    c.is_lower_x = (b == CH_X);
    return c;
  endfunction

  assign text_i.ready = !valid_q || char_ready_i;
  assign char_d       = classify(text_i.text_byte);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (text_i.ready) begin
      valid_q <= text_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (text_i.valid && text_i.ready) begin
      char_q <= char_d;
    end
  end

  assign char_valid_o = valid_q;
  assign char_o       = char_q;

endmodule

// File: rtl/jsv_queue.sv
`timescale 1ns / 1ps

module jsv_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  jsv_pkg::char_t push_data_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output jsv_pkg::char_t pop_data_o
);
  import jsv_pkg::*;

  char_t                slot_q [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wptr_q, wptr_d;
  logic [QPTR_BITS-1:0] rptr_q, rptr_d;
  logic [QCNT_BITS-1:0] count_q, count_d;
  logic                 push, pop;

  function automatic logic [QPTR_BITS-1:0] ptr_next(input logic [QPTR_BITS-1:0] p);
    return (p == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_BITS'(1);
  endfunction

  assign push_ready_o = (count_q != QCNT_BITS'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = slot_q[rptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wptr_d  = push ? ptr_next(wptr_q) : wptr_q;
    rptr_d  = pop ? ptr_next(rptr_q) : rptr_q;
    count_d = count_q;
    case ({push, pop})
      2'b10:   count_d = count_q + QCNT_BITS'(1);
      2'b01:   count_d = count_q - QCNT_BITS'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wptr_q] <= push_data_i;
    end
  end

endmodule

// File: rtl/jsv_back.sv
`timescale 1ns / 1ps

module jsv_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           char_valid_i,
  output logic           char_ready_o,
  input  jsv_pkg::char_t char_i,
  jsv_result_if.source   result_o
);
  import jsv_pkg::*;

  phase_e      phase_q, phase_d, phase_adv;
  status_e     err_q, err_d, err_adv;
  vtype_e      kind_q, kind_d, kind_adv;
  logic [2:0]  pos_q, pos_d, pos_adv, pos_inc;
  offset_t     boff_q, boff_d;
  offset_t     start_q, start_d, start_adv;
  offset_t     span_q, span_d, span_adv;
  logic        step_take, step_start;
  logic        fire, finish;

  logic        out_valid_q;
  status_e     out_status_q;
  vtype_e      out_type_q;
  out_len_t    out_start_q, out_len_q;

  // Ordinary bytes never wait on the output; only the terminator needs a free result slot.
  assign char_ready_o = !char_i.is_nul || !out_valid_q || result_o.ready;
  assign fire         = char_valid_i && char_ready_o;
  assign finish       = fire && char_i.is_nul;
  assign pos_inc      = pos_q + 3'd1;

  // Parser transition for one character.
  always_comb begin
    phase_adv  = phase_q;
    err_adv    = err_q;
    kind_adv   = kind_q;
    pos_adv    = pos_q;
    step_take  = 1'b0;
    step_start = 1'b0;
    unique case (phase_q) inside
      PH_LEAD: begin
        if (char_i.is_ws) begin
          phase_adv = PH_LEAD;
        end else if (char_i.is_nul) begin
          phase_adv = PH_ERR;
          err_adv   = ST_EXPECT;
        end else if (char_i.text_byte == CH_N || char_i.text_byte == CH_F ||
                     char_i.text_byte == CH_T) begin
          kind_adv   = (char_i.text_byte == CH_N) ? TY_NULL :
                       (char_i.text_byte == CH_F) ? TY_FALSE : TY_TRUE;
          pos_adv    = 3'd1;
          step_start = 1'b1;
          phase_adv  = PH_LIT;
        end else begin
          kind_adv = TY_NUMBER;
          if (char_i.is_minus) begin
            step_start = 1'b1;
            phase_adv  = PH_SIGN;
          end else if (char_i.is_zero) begin
            step_start = 1'b1;
            phase_adv  = PH_ZERO;
          end else if (char_i.is_nonzero) begin
            step_start = 1'b1;
            phase_adv  = PH_INT;
          end else begin
            phase_adv = PH_ERR;
            err_adv   = ST_INVALID;
          end
        end
      end
      PH_LIT: begin
        if (char_i.is_nul || char_i.text_byte != lit_char(kind_q, pos_q)) begin
          phase_adv = PH_ERR;
          err_adv   = ST_INVALID;
        end else begin
          pos_adv   = pos_inc;
          step_take = 1'b1;
          phase_adv = (lit_char(kind_q, pos_inc) == CH_NUL) ? PH_TRAIL : PH_LIT;
        end
      end
      PH_SIGN: begin
        if (char_i.is_zero) begin
          step_take = 1'b1;
          phase_adv = PH_ZERO;
        end else if (char_i.is_nonzero) begin
          step_take = 1'b1;
          phase_adv = PH_INT;
        end else begin
          phase_adv = PH_ERR;
          err_adv   = ST_INVALID;
        end
      end
      PH_ZERO, PH_INT, PH_FRAC, PH_EXPDIG: begin
        if (phase_q == PH_ZERO && (char_i.is_digit || char_i.is_lower_x)) begin
          phase_adv = PH_ERR;
          err_adv   = ST_INVALID;
        end else if (char_i.is_digit) begin
          step_take = 1'b1;
          phase_adv = (phase_q == PH_INT) ? PH_INT : phase_q;
        end else if (char_i.is_dot && (phase_q == PH_ZERO || phase_q == PH_INT)) begin
          step_take = 1'b1;
          phase_adv = PH_DOT;
        end else if (char_i.is_exp && phase_q != PH_EXPDIG) begin
          step_take = 1'b1;
          phase_adv = PH_EXP;
        end else if (char_i.is_nul || char_i.is_ws) begin
          phase_adv = PH_TRAIL;
        end else begin
          phase_adv = PH_ERR;
          err_adv   = ST_NOT_SINGULAR;
        end
      end
      PH_DOT, PH_EXPSIGN: begin
        if (char_i.is_digit) begin
          step_take = 1'b1;
          phase_adv = (phase_q == PH_DOT) ? PH_FRAC : PH_EXPDIG;
        end else begin
          phase_adv = PH_ERR;
          err_adv   = ST_INVALID;
        end
      end
      PH_EXP: begin
        if (char_i.is_sign) begin
          step_take = 1'b1;
          phase_adv = PH_EXPSIGN;
        end else if (char_i.is_digit) begin
          step_take = 1'b1;
          phase_adv = PH_EXPDIG;
        end else begin
          phase_adv = PH_ERR;
          err_adv   = ST_INVALID;
        end
      end
      PH_TRAIL: begin
        if (char_i.is_nul || char_i.is_ws) begin
          phase_adv = PH_TRAIL;
        end else begin
          phase_adv = PH_ERR;
          err_adv   = ST_NOT_SINGULAR;
        end
      end
      PH_ERR: begin
        phase_adv = PH_ERR;
      end
      default: begin
        phase_adv = PH_LEAD;
      end
    endcase
  end

  // Counters and the return to the start state once the terminator is taken.
  always_comb begin
    start_adv = step_start ? boff_q : start_q;
    span_adv  = step_start ? '0 : span_q;
    if (step_take || step_start) begin
      span_adv = sat_inc(span_adv);
    end

    phase_d = phase_q;
    err_d   = err_q;
    kind_d  = kind_q;
    pos_d   = pos_q;
    boff_d  = boff_q;
    start_d = start_q;
    span_d  = span_q;
    if (finish) begin
      phase_d = PH_LEAD;
      err_d   = ST_OK;
      kind_d  = TY_NULL;
      pos_d   = '0;
      boff_d  = '0;
      start_d = '0;
      span_d  = '0;
    end else if (fire) begin
      phase_d = phase_adv;
      err_d   = err_adv;
      kind_d  = kind_adv;
      pos_d   = pos_adv;
      boff_d  = sat_inc(boff_q);
      start_d = start_adv;
      span_d  = span_adv;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_LEAD;
      err_q       <= ST_OK;
      kind_q      <= TY_NULL;
      pos_q       <= '0;
      boff_q      <= '0;
      start_q     <= '0;
      span_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      err_q   <= err_d;
      kind_q  <= kind_d;
      pos_q   <= pos_d;
      boff_q  <= boff_d;
      start_q <= start_d;
      span_q  <= span_d;
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      if (phase_adv == PH_ERR) begin
        out_status_q <= err_adv;
        out_type_q   <= TY_NULL;
        out_start_q  <= '0;
        out_len_q    <= '0;
      end else begin
        out_status_q <= ST_OK;
        out_type_q   <= kind_adv;
        out_start_q  <= clamp_out(start_adv);
        out_len_q    <= clamp_out(span_adv);
      end
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.status       = out_status_q;
  assign result_o.value_type   = out_type_q;
  assign result_o.value_start  = out_start_q;
  assign result_o.value_length = out_len_q;

endmodule

// File: rtl/jsv_checker.sv
`timescale 1ns / 1ps

module jsv_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     out_valid_i,
  input logic                     out_ready_i,
  input logic [1:0]               status_i,
  input logic [1:0]               value_type_i,
  input logic [jsv_pkg::OUT_BITS-1:0] value_start_i,
  input logic [jsv_pkg::OUT_BITS-1:0] value_length_i
);
  import jsv_pkg::*;

  // A failed text reports no type, offset or length.
  a_error_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && status_i != ST_OK) |->
      (value_type_i == TY_NULL && value_start_i == '0 && value_length_i == '0))
    else $error("error result carries non-zero fields");

  // A recognised literal always spans exactly its spelling.
  a_literal_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && status_i == ST_OK && value_type_i != TY_NUMBER) |->
      (value_length_i == ((value_type_i == TY_FALSE) ? OUT_BITS'(5) : OUT_BITS'(4))))
    else $error("literal length does not match its spelling");

  // A successful number has at least one character.
  a_number_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && status_i == ST_OK && value_type_i == TY_NUMBER) |->
      (value_length_i != '0))
    else $error("number reported with zero length");

  // A stalled result holds.
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(status_i) && $stable(value_type_i) &&
       $stable(value_start_i) && $stable(value_length_i)))
    else $error("result changed while stalled");

endmodule

bind json_scalar_validator jsv_checker u_jsv_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (result_o.valid),
  .out_ready_i    (result_o.ready),
  .status_i       (result_o.status),
  .value_type_i   (result_o.value_type),
  .value_start_i  (result_o.value_start),
  .value_length_i (result_o.value_length)
);

// File: dv/json_scalar_validator_tb.sv
`timescale 1ns / 1ps

module json_scalar_validator_tb;
  import jsv_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 2_000_000;
  localparam int unsigned PHASE_BYTES   = 280;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned SETTLE_CYCLES = 24;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  typedef struct packed {
    status_e  status;
    vtype_e   vtype;
    out_len_t start;
    out_len_t length;
  } verdict_t;

  logic clk_i;
  logic rst_ni;

  jsv_text_if   txt ();
  jsv_result_if res ();

  json_scalar_validator i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .text_i   (txt),
    .result_o (res)
  );

  logic [7:0] text_bytes_q[$];
  logic [7:0] scratch_q[$];
  verdict_t   verdicts_q[$];

  idle_mode_e  idle_mode;
  logic        txt_took;
  int unsigned bytes_pushed;
  int unsigned bytes_taken;
  int unsigned fail_count;
  int unsigned cycle_count;
  int unsigned hold_req;
  int unsigned hold_seen;
  int unsigned hold_left;

  // Predictor state.
  phase_e     scan_ph;
  vtype_e     scan_kind;
  logic [2:0] scan_pos;
  offset_t    scan_off;
  offset_t    scan_start;
  offset_t    scan_span;
  status_e    scan_err;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
  endfunction

  function automatic logic is_num(input logic [7:0] c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

  function automatic offset_t bump(input offset_t v);
    return (v == '1) ? v : v + offset_t'(1);
  endfunction

  function automatic out_len_t to_field(input offset_t v);
    logic [63:0] w;
    w = 64'(v);
    return (w > 64'({OUT_BITS{1'b1}})) ? '1 : out_len_t'(w);
  endfunction

  function automatic logic [7:0] spelling(input vtype_e k, input logic [2:0] p);
    string s;
    if (k == TY_NULL) begin
      s = "null";
    end else if (k == TY_FALSE) begin
      s = "false";
    end else begin
      s = "true";
    end
    return (int'(p) < s.len()) ? s[p] : CH_NUL;
  endfunction

  task automatic scan_clear();
    scan_ph    = PH_LEAD;
    scan_kind  = TY_NULL;
    scan_pos   = '0;
    scan_off   = '0;
    scan_start = '0;
    scan_span  = '0;
    scan_err   = ST_OK;
  endtask

  task automatic scan_fail(input status_e code);
    scan_err = code;
    scan_ph  = PH_ERR;
  endtask

  task automatic scan_take(input phase_e next);
    scan_ph   = next;
    scan_span = bump(scan_span);
  endtask

  task automatic scan_open(input phase_e next);
    scan_start = scan_off;
    scan_span  = '0;
    scan_take(next);
  endtask

  // A complete value has just ended; c is the byte after it.
  task automatic scan_after(input logic [7:0] c);
    if ((c == CH_NUL) || is_space(c)) begin
      scan_ph = PH_TRAIL;
    end else begin
      scan_fail(ST_NOT_SINGULAR);
    end
  endtask

  task automatic scan_byte(input logic [7:0] c);
    verdict_t v;
    case (scan_ph)
      PH_LEAD: begin
        if (!is_space(c)) begin
          if (c == CH_NUL) begin
            scan_fail(ST_EXPECT);
          end else if ((c == CH_N) || (c == CH_F) || (c == CH_T)) begin
            if (c == CH_N) begin
              scan_kind = TY_NULL;
            end else if (c == CH_F) begin
              scan_kind = TY_FALSE;
            end else begin
              scan_kind = TY_TRUE;
            end
            scan_pos = 3'd1;
            scan_open(PH_LIT);
          end else begin
            scan_kind = TY_NUMBER;
            if (c == CH_MINUS) begin
              scan_open(PH_SIGN);
            end else if (c == CH_0) begin
              scan_open(PH_ZERO);
            end else if ((c >= CH_1) && (c <= CH_9)) begin
              scan_open(PH_INT);
            end else begin
              scan_fail(ST_INVALID);
            end
          end
        end
      end
      PH_LIT: begin
        if ((c == CH_NUL) || (c != spelling(scan_kind, scan_pos))) begin
          scan_fail(ST_INVALID);
        end else begin
          scan_pos = scan_pos + 3'd1;
          scan_take(PH_LIT);
          if (spelling(scan_kind, scan_pos) == CH_NUL) begin
            scan_ph = PH_TRAIL;
          end
        end
      end
      PH_SIGN: begin
        if (c == CH_0) begin
          scan_take(PH_ZERO);
        end else if ((c >= CH_1) && (c <= CH_9)) begin
          scan_take(PH_INT);
        end else begin
          scan_fail(ST_INVALID);
        end
      end
      PH_ZERO: begin
        if (is_num(c) || (c == CH_X)) begin
          scan_fail(ST_INVALID);
        end else if (c == CH_DOT) begin
          scan_take(PH_DOT);
        end else if ((c == CH_E) || (c == CH_UP_E)) begin
          scan_take(PH_EXP);
        end else begin
          scan_after(c);
        end
      end
      PH_INT: begin
        if (is_num(c)) begin
          scan_take(PH_INT);
        end else if (c == CH_DOT) begin
          scan_take(PH_DOT);
        end else if ((c == CH_E) || (c == CH_UP_E)) begin
          scan_take(PH_EXP);
        end else begin
          scan_after(c);
        end
      end
      PH_DOT: begin
        if (is_num(c)) begin
          scan_take(PH_FRAC);
        end else begin
          scan_fail(ST_INVALID);
        end
      end
      PH_FRAC: begin
        if (is_num(c)) begin
          scan_take(PH_FRAC);
        end else if ((c == CH_E) || (c == CH_UP_E)) begin
          scan_take(PH_EXP);
        end else begin
          scan_after(c);
        end
      end
      PH_EXP: begin
        if ((c == CH_PLUS) || (c == CH_MINUS)) begin
          scan_take(PH_EXPSIGN);
        end else if (is_num(c)) begin
          scan_take(PH_EXPDIG);
        end else begin
          scan_fail(ST_INVALID);
        end
      end
      PH_EXPSIGN: begin
        if (is_num(c)) begin
          scan_take(PH_EXPDIG);
        end else begin
          scan_fail(ST_INVALID);
        end
      end
      PH_EXPDIG: begin
        if (is_num(c)) begin
          scan_take(PH_EXPDIG);
        end else begin
          scan_after(c);
        end
      end
      PH_TRAIL: begin
        scan_after(c);
      end
      default: begin
      end
    endcase
    if (c != CH_NUL) begin
      scan_off = bump(scan_off);
    end else begin
      if (scan_ph == PH_ERR) begin
        v = '{status: scan_err, vtype: TY_NULL, start: '0, length: '0};
      end else begin
        v = '{status: ST_OK, vtype: scan_kind, start: to_field(scan_start),
              length: to_field(scan_span)};
      end
      verdicts_q.push_back(v);
      scan_clear();
    end
  endtask

  function automatic logic sender_idle();
    int unsigned r;
    r = $urandom_range(99);
    case (idle_mode)
      IDLE_SENDER: return r < 72;
      IDLE_BOTH:   return r < 13;
      default:     return 1'b0;
    endcase
  endfunction

  function automatic logic receiver_stall();
    int unsigned r;
    r = $urandom_range(99);
    case (idle_mode)
      IDLE_RECEIVER: return r < 72;
      IDLE_BOTH:     return r < 13;
      default:       return 1'b0;
    endcase
  endfunction

  task automatic push_byte(input logic [7:0] c);
    text_bytes_q.push_back(c);
    bytes_pushed++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      push_byte(s[i]);
    end
    push_byte(CH_NUL);
  endtask

  task automatic push_spaces(input int unsigned n);
    string ws;
    ws = " \t\n\r";
    repeat (n) push_byte(ws[$urandom_range(3)]);
  endtask

  task automatic scratch_digits(input int unsigned n);
    repeat (n) scratch_q.push_back(CH_0 + 8'($urandom_range(9)));
  endtask

  // Builds one well-formed scalar in the scratch queue.
  task automatic make_value();
    string lit;
    int unsigned pick;
    pick = $urandom_range(5);
    if (pick < 3) begin
      lit = (pick == 0) ? "null" : (pick == 1) ? "false" : "true";
      for (int i = 0; i < lit.len(); i++) begin
        scratch_q.push_back(lit[i]);
      end
    end else begin
      if ($urandom_range(1) == 1) scratch_q.push_back(CH_MINUS);
      if ($urandom_range(3) == 0) begin
        scratch_q.push_back(CH_0);
      end else begin
        scratch_q.push_back(CH_1 + 8'($urandom_range(8)));
        scratch_digits($urandom_range(4));
      end
      if ($urandom_range(1) == 1) begin
        scratch_q.push_back(CH_DOT);
        scratch_digits($urandom_range(1, 3));
      end
      if ($urandom_range(2) == 0) begin
        scratch_q.push_back(($urandom_range(1) == 1) ? CH_E : CH_UP_E);
        pick = $urandom_range(2);
        if (pick == 1) scratch_q.push_back(CH_PLUS);
        if (pick == 2) scratch_q.push_back(CH_MINUS);
        scratch_digits($urandom_range(1, 3));
      end
    end
  endtask

  // Changes the scalar in the scratch queue in one of several ways; the result may still be well-formed.
  task automatic break_value();
    string tricky;
    int unsigned p;
    logic [7:0] c;
    tricky = "0xXeE.+-9a ";
    p = $urandom_range(scratch_q.size() - 1);
    c = ($urandom_range(1) == 1) ? tricky[$urandom_range(tricky.len() - 1)]
                                 : 8'($urandom_range(1, 255));
    case ($urandom_range(3))
      0: scratch_q[p] = c;
      1: begin
        while (scratch_q.size() > p) void'(scratch_q.pop_back());
      end
      2: scratch_q.insert(p, c);
      default: scratch_q.push_back(c);
    endcase
  endtask

  task automatic make_random_text();
    int unsigned pick;
    int unsigned n;
    scratch_q.delete();
    pick = $urandom_range(99);
    if (pick < 15) begin
      n = $urandom_range(1, 6);
      repeat (n) scratch_q.push_back(8'($urandom_range(1, 255)));
    end else begin
      make_value();
      if (pick >= 65) break_value();
    end
    push_spaces(($urandom_range(1) == 1) ? $urandom_range(1, 3) : 0);
    foreach (scratch_q[i]) push_byte(scratch_q[i]);
    push_spaces(($urandom_range(2) == 0) ? $urandom_range(1, 2) : 0);
    push_byte(CH_NUL);
  endtask

  task automatic push_directed();
    push_text("true");
    push_text("false");
    push_text("null");
    push_text(" \t\n\r null \r\n\t ");
    push_text("");
    push_text(" \t\r\n");
    push_text("?");
    push_text("-");
    push_text("-x");
    push_text("0123");
    push_text("0x1");
    push_text("-0x");
    push_text("0X");
    push_text("1.");
    push_text("1.e3");
    push_text("1e");
    push_text("1e+");
    push_text("1E-5");
    push_text("-0.0e+12");
    push_text("nul");
    push_text("tRue");
    push_text("true x");
    push_text("0 1");
    push_text("123456789.25e-07");
    push_byte(8'hFF);
    push_byte(8'h80);
    push_byte(CH_NUL);
  endtask

  task automatic wait_sent();
    while (bytes_taken != bytes_pushed) @(negedge clk_i);
  endtask

  // Sender: a request stays on the bus until it has been taken.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!txt.valid || txt_took) begin
        if ((text_bytes_q.size() > 0) && !sender_idle()) begin
          txt.valid     <= 1'b1;
          txt.text_byte <= text_bytes_q.pop_front();
        end else begin
          txt.valid <= 1'b0;
        end
      end
      res.ready <= (hold_left == 0) && !receiver_stall();
    end
  end

  always @(posedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("[json_scalar_validator] ERROR");
      $finish;
    end
  end

  // Monitor: feeds taken bytes to the predictor and checks every result.
  always @(posedge clk_i) begin
    verdict_t want;
    if (rst_ni) begin
      txt_took = txt.valid && txt.ready;
      if (txt_took) begin
        scan_byte(txt.text_byte);
        bytes_taken++;
      end
      if (res.valid && res.ready) begin
        if (verdicts_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result status %0d type %0d start %0d length %0d",
                   $time, res.status, res.value_type, res.value_start, res.value_length);
        end else begin
          want = verdicts_q.pop_front();
          if ((res.status != want.status) || (res.value_type != want.vtype) ||
              (res.value_start != want.start) || (res.value_length != want.length)) begin
            fail_count++;
            $display("%0t: expected status %0d type %0d start %0d length %0d, got %0d %0d %0d %0d",
                     $time, want.status, want.vtype, want.start, want.length,
                     res.status, res.value_type, res.value_start, res.value_length);
          end
        end
      end
    end
  end

  initial begin
    int unsigned phase_base;
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    txt.valid     = 1'b0;
    txt.text_byte = CH_NUL;
    res.ready     = 1'b0;
    idle_mode     = IDLE_NONE;
    txt_took      = 1'b0;
    bytes_pushed  = 0;
    bytes_taken   = 0;
    fail_count    = 0;
    cycle_count   = 0;
    hold_req      = 0;
    hold_seen     = 0;
    hold_left     = 0;
    scan_clear();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int m = IDLE_NONE; m <= IDLE_BOTH; m++) begin
      idle_mode = idle_mode_e'(m);
      // In the first phase the receiver holds off while bytes keep coming, so the
      // block has to back up its input.
      if (idle_mode == IDLE_NONE) hold_req++;
      phase_base = bytes_pushed;
      while (bytes_pushed - phase_base < PHASE_BYTES) make_random_text();
      wait_sent();
      if (idle_mode == IDLE_NONE) begin
        push_directed();
        wait_sent();
      end
    end

    while (verdicts_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if ((fail_count == 0) && (verdicts_q.size() == 0)) begin
      $display("[json_scalar_validator] OK");
    end else begin
      $display("[json_scalar_validator] ERROR");
    end
    $finish;
  end

endmodule
